// ----- rtl/aes128_block_cipher_assert.svh -----
// ---------------------------------------------------------------------------
// AES-128 assertion macros
// Shared immediate-free concurrent assertion helpers for the cipher RTL.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// A condition that must hold in the cycle after its trigger.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/aes128_pkg.sv -----
// ---------------------------------------------------------------------------
// AES-128 package
// Types, tables and round functions shared by the cipher RTL.
// ---------------------------------------------------------------------------
`default_nettype none
package aes128_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned KeyEntries = 22;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   function automatic byte_type sbox(input byte_type v);
      byte_type r;
      unique case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Inverse S-box as a composite: affine inverse then field inverse by
   // search is too deep, so it is tabulated by inverting the forward table.
   function automatic byte_type inv_sbox(input byte_type v);
      byte_type r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (sbox(byte_type'(i)) == v) begin
            r = byte_type'(i);
         end
      end
      return r;
   endfunction

   function automatic byte_type xt(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type rcon(input logic [3:0] r);
      byte_type c;
      unique case (r)
         4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
         4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
         4'd9: c = 8'h1b; 4'd10: c = 8'h36;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Byte i of the state sits at bits 127-8i.
   function automatic byte_type get_b(input block_type s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic block_type fwd_round(input block_type s, input logic last);
      block_type t, u;
      byte_type a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(get_b(s, 4 * ((c + r) % 4) + r));
         end
      end
      u = t;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = get_b(t, 4 * c); a1 = get_b(t, 4 * c + 1);
            a2 = get_b(t, 4 * c + 2); a3 = get_b(t, 4 * c + 3);
            u[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            u[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            u[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            u[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
      return u;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = inv_sbox(get_b(s, 4 * c + r));
         end
      end
      return t;
   endfunction

   function automatic byte_type mul_e(input byte_type a, input byte_type b,
                                      input byte_type c, input byte_type d);
      byte_type a2, a4, a8, b2, b4, b8, c2, c4, c8, d2, d4, d8;
      a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
      b2 = xt(b); b4 = xt(b2); b8 = xt(b4);
      c2 = xt(c); c4 = xt(c2); c8 = xt(c4);
      d2 = xt(d); d4 = xt(d2); d8 = xt(d4);
      // 14a ^ 11b ^ 13c ^ 9d
      return (a8 ^ a4 ^ a2) ^ (b8 ^ b2 ^ b) ^ (c8 ^ c4 ^ c) ^ (d8 ^ d);
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type u;
      byte_type a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_b(s, 4 * c); a1 = get_b(s, 4 * c + 1);
         a2 = get_b(s, 4 * c + 2); a3 = get_b(s, 4 * c + 3);
         u[127 - 32 * c -: 8] = mul_e(a0, a1, a2, a3);
         u[119 - 32 * c -: 8] = mul_e(a1, a2, a3, a0);
         u[111 - 32 * c -: 8] = mul_e(a2, a3, a0, a1);
         u[103 - 32 * c -: 8] = mul_e(a3, a0, a1, a2);
      end
      return u;
   endfunction

   function automatic block_type next_key(input block_type k, input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/aes128_block_cipher.sv -----
// ---------------------------------------------------------------------------
// AES-128 block cipher
// Iterative single-block AES-128 encryption and decryption.
// ---------------------------------------------------------------------------
// The key is written through the csr_ channel, index 0 for the upper half and
// index 1 for the lower. Each key write starts an expansion that fills the
// round key store, one round key a cycle; no block is taken then.
// A key write takes precedence over a block offered in the same cycle.
// A block transfer on req_ carries the mode in req_tuser and the block in
// req_tdata. The shared round unit then runs one round a cycle: the block is
// loaded with the first key addition in the cycle of transfer and ten rounds
// follow before the result is offered. A new block can be taken in the cycle
// after the result transfer; no block is taken while one is in progress. The
// result is held in rsp_tdata until it transfers; while the receiver stalls,
// no new block is accepted. Reset returns the block to idle with the key
// registers at zero; the round key store is only defined once a key write has
// been made.
// ---------------------------------------------------------------------------
`default_nettype none
`include "aes128_block_cipher_assert.svh"
module aes128_block_cipher (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // block_upper, block_lower... bits 63:0 block_upper
   input  wire logic         req_tuser,  // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,  // out_upper in 63:0, out_lower in 127:64
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_data
);
   import aes128_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] key_hi_ff, key_lo_ff;
   block_type   rk_ff [0:10];
   block_type   exp_ff;
   block_type   st_ff;
   logic        mode_ff;
   logic [3:0]  rnd_ff;
   block_type   rk_cur, st_round, st_next, blk_in;

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {st_ff[63:0], st_ff[127:64]};
   assign blk_in     = {req_tdata[63:0], req_tdata[127:64]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) state_in = ST_EXPAND;
            else if (req_tvalid) state_in = ST_RUN;
         end
         ST_EXPAND: if (rnd_ff == 4'(NumRounds)) state_in = ST_IDLE;
         ST_RUN: if (rnd_ff == 4'(NumRounds)) state_in = ST_DONE;
         ST_DONE: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Round key used by the round unit, and the round itself in either mode.
   always_comb begin
      rk_cur = mode_ff ? rk_ff[4'(NumRounds) - rnd_ff] : rk_ff[rnd_ff];
      if (!mode_ff) begin
         st_round = fwd_round(st_ff, rnd_ff == 4'(NumRounds));
         st_next  = st_round ^ rk_cur;
      end else begin
         st_round = inv_shift_sub(st_ff) ^ rk_cur;
         st_next  = (rnd_ff == 4'(NumRounds)) ? st_round : inv_mix(st_round);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         rnd_ff    <= '0;
         mode_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rnd_ff <= 4'd1;
               if (csr_valid) begin
                  if (csr_index) begin
                     key_lo_ff <= csr_data;
                     exp_ff <= {key_hi_ff, csr_data};
                     rk_ff[0] <= {key_hi_ff, csr_data};
                  end else begin
                     key_hi_ff <= csr_data;
                     exp_ff <= {csr_data, key_lo_ff};
                     rk_ff[0] <= {csr_data, key_lo_ff};
                  end
               end else if (req_tvalid) begin
                  mode_ff <= req_tuser;
                  st_ff <= blk_in ^ (req_tuser ? rk_ff[NumRounds] : rk_ff[0]);
               end
            end
            ST_EXPAND: begin
               exp_ff <= next_key(exp_ff, rnd_ff);
               rk_ff[rnd_ff] <= next_key(exp_ff, rnd_ff);
               rnd_ff <= rnd_ff + 4'd1;
            end
            ST_RUN: begin
               st_ff <= st_next;
               rnd_ff <= rnd_ff + 4'd1;
            end
            ST_DONE: ;
            default: ;
         endcase
      end
   end

   `AES_ASSERT_IMPL(a_rdy_excl, clock, reset, rsp_tvalid, !req_tready)
   `AES_ASSERT_IMPL(a_rnd_range, clock, reset, state_ff == ST_RUN, rnd_ff <= 4'(NumRounds))
   `AES_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives key writes and blocks in both modes against a self-contained cipher
// model, with random gaps on both streams, and checks every result in order.
// ---------------------------------------------------------------------------
module testbench;

   localparam logic KeyUpperIdx = 1'b0;
   localparam logic KeyLowerIdx = 1'b1;
   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // block_upper, block_lower
   logic         req_tuser = 1'b0;  // mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;  // out_upper, out_lower
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [63:0]  csr_data = '0;

   logic [7:0]   sub_tab [256];
   logic [7:0]   inv_sub_tab [256];
   logic [127:0] round_keys [11];
   logic [63:0]  key_hi = '0;
   logic [63:0]  key_lo = '0;
   logic [127:0] expected_blocks [$];
   int           errors = 0;
   int           blocks_sent = 0;
   int           blocks_checked = 0;
   int           key_writes = 0;
   int           stall_left = 0;
   bit           quiet = 1'b0;

   aes128_block_cipher i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl8(logic [7:0] v, int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   task automatic build_sbox();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         sub_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                      ^ rotl8(inv, 4) ^ 8'h63;
      end
      for (int x = 0; x < 256; x++) inv_sub_tab[sub_tab[x]] = x[7:0];
   endtask

   task automatic expand_round_keys();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {sub_tab[t[23:16]] ^ rc, sub_tab[t[15:8]], sub_tab[t[7:0]],
                 sub_tab[t[31:24]]};
            rc = gf_mul(rc, 8'h02);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r < 11; r++) begin
         round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
      end
   endtask

   // Returns the result with byte 0 in the top bits.
   function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] acc;
      logic [7:0] m [4];
      logic [127:0] res;
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
      if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[dec ? 10 : 0][127 - 8 * i -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               if (dec) t[4 * ((c + r) % 4) + r] = inv_sub_tab[s[4 * c + r]];
               else t[4 * c + r] = sub_tab[s[4 * ((c + r) % 4) + r]];
            end
         end
         s = t;
         if (dec) begin
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[10 - rnd][127 - 8 * i -: 8];
         end
         if (rnd != 10) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  acc = 8'h00;
                  for (int k = 0; k < 4; k++) acc ^= gf_mul(s[4 * c + k], m[(k - r + 4) % 4]);
                  t[r] = acc;
               end
               for (int r = 0; r < 4; r++) s[4 * c + r] = t[r];
            end
         end
         if (!dec) begin
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[rnd][127 - 8 * i -: 8];
         end
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
      return res;
   endfunction

   function automatic int rand_gap();
      int p;
      p = $urandom_range(99);
      if (quiet || p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s at %0t: got %h, expected %h", what, $realtime, got, want);
      errors++;
   endtask

   // Keys are only written once the cipher has gone quiet.
   task automatic write_key(logic idx, logic [63:0] value);
      wait (expected_blocks.size() == 0);
      repeat (15) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == KeyUpperIdx) key_hi = value;
      else key_lo = value;
      expand_round_keys();
      key_writes++;
   endtask

   task automatic load_key(logic [63:0] hi, logic [63:0] lo);
      write_key(KeyUpperIdx, hi);
      write_key(KeyLowerIdx, lo);
   endtask

   task automatic send_block(logic mode, logic [63:0] hi, logic [63:0] lo);
      int gap;
      logic [127:0] res;
      gap = rand_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {lo, hi};
      do @(posedge clock); while (!req_tready);
      res = cipher_block(mode, {hi, lo});
      expected_blocks.push_back({res[63:0], res[127:64]});
      blocks_sent++;
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= rand_gap();
      end
   end

   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $display("unexpected result transfer at %0t: %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_tdata[63:0] !== want[63:0])
               report_mismatch("out_upper", rsp_tdata[63:0], want[63:0]);
            if (rsp_tdata[127:64] !== want[127:64])
               report_mismatch("out_lower", rsp_tdata[127:64], want[127:64]);
            blocks_checked++;
         end
      end
   end

   task automatic test_standard_vector();
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(ModeEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(ModeDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      end_burst();
   endtask

   task automatic test_extremes();
      load_key('0, '0);
      send_block(ModeEncrypt, '0, '0);
      send_block(ModeDecrypt, '0, '0);
      send_block(ModeEncrypt, '1, '1);
      send_block(ModeDecrypt, '1, '1);
      end_burst();
      load_key('1, '1);
      send_block(ModeEncrypt, '0, '1);
      send_block(ModeDecrypt, '1, '0);
      send_block(ModeEncrypt, '1, '1);
      send_block(ModeDecrypt, '0, '0);
      end_burst();
   endtask

   // Each half written alone must re-expand from both registers as they are.
   task automatic test_key_halves();
      write_key(KeyUpperIdx, 64'h2b7e151628aed2a6);
      send_block(ModeEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block(ModeDecrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
      end_burst();
      write_key(KeyLowerIdx, 64'habf7158809cf4f3c);
      send_block(ModeEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block(ModeDecrypt, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
      end_burst();
      write_key(KeyUpperIdx, rand64());
      send_block(ModeEncrypt, rand64(), rand64());
      end_burst();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            3: load_key('0, rand64());
            6: load_key('1, '1);
            default: load_key(rand64(), rand64());
         endcase
         quiet = (phase % 3 == 1);
         repeat (190) send_block(1'($urandom_range(1)), rand64(), rand64());
         end_burst();
      end
      quiet = 1'b0;
   endtask

   initial begin
      build_sbox();
      expand_round_keys();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_standard_vector();
      test_extremes();
      test_key_halves();
      test_random_traffic();
      wait (expected_blocks.size() == 0);
      repeat (30) @(posedge clock);
      $display("Covered %0d blocks in both modes under %0d key writes.", blocks_sent, key_writes);
      $display("Checked %0d results, %0d mismatches.", blocks_checked, errors);
      if (errors == 0 && expected_blocks.size() == 0) begin
         $display("PASS aes128_block_cipher");
      end else begin
         $display("FAIL aes128_block_cipher");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results outstanding.", expected_blocks.size());
      $display("FAIL aes128_block_cipher");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/aes128_pkg.sv
rtl/aes128_block_cipher.sv
dv/testbench.sv
